### sv/sdc_pkg.sv
// Shared types, constants and the control program of the stereo dynamics compressor.
`timescale 1ns / 1ps

package sdc_pkg;

  localparam int PRE_W    = 24;
  localparam int POST_W   = 24;
  localparam int THR_W    = 21;
  localparam int INV_W    = 21;
  localparam int FACTOR_W = 31;

  localparam int GAIN_W   = 32;
  localparam int LEVEL_W  = 32;
  localparam int TARGET_W = 35;
  localparam int G_W      = 36;
  localparam int B_W      = 31;
  localparam int THR_SHIFT = 8;

  localparam logic [GAIN_W-1:0] UNITY_Q28 = 32'd268435456;

  localparam logic [PRE_W-1:0]    PRE_RESET     = 24'd1048576;
  localparam logic [POST_W-1:0]   POST_RESET    = 24'd1048576;
  localparam logic [THR_W-1:0]    THR_RESET     = 21'd1048576;
  localparam logic [INV_W-1:0]    INV_RESET     = 21'd349525;
  localparam logic [FACTOR_W-1:0] ATTACK_RESET  = 31'd1068584000;
  localparam logic [FACTOR_W-1:0] RELEASE_RESET = 31'd1074000000;

  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;
  localparam int REG_IW  = 3;

  localparam logic [REG_IW-1:0] REG_PRE_GAIN  = 3'd0;
  localparam logic [REG_IW-1:0] REG_POST_GAIN = 3'd1;
  localparam logic [REG_IW-1:0] REG_THRESHOLD = 3'd2;
  localparam logic [REG_IW-1:0] REG_INV_RATIO = 3'd3;
  localparam logic [REG_IW-1:0] REG_ATTACK    = 3'd4;
  localparam logic [REG_IW-1:0] REG_RELEASE   = 3'd5;

  localparam int NUM_STEPS = 14;
  localparam int STEP_W    = $clog2(NUM_STEPS);

  localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_FIRST = 4'd1;
  localparam logic [STEP_W-1:0] STEP_LAST  = 4'd13;

  typedef struct packed {
    logic [PRE_W-1:0]    pre_gain;
    logic [POST_W-1:0]   post_gain;
    logic [THR_W-1:0]    threshold_level;
    logic [INV_W-1:0]    inverse_ratio;
    logic [FACTOR_W-1:0] attack_factor;
    logic [FACTOR_W-1:0] release_factor;
  } cfg_t;

  typedef enum logic [2:0] {
    A_NONE,
    A_PEAK,
    A_DIFF,
    A_GAIN,
    A_MAGL,
    A_MAGR
  } a_sel_t;

  typedef enum logic [2:0] {
    B_NONE,
    B_PRE,
    B_INV,
    B_FACTOR,
    B_POST,
    B_GHI,
    B_GLO
  } b_sel_t;

  typedef enum logic [1:0] {
    J_ALWAYS,
    J_WAIT_IN,
    J_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    logic              mul_en;
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    logic              wr_level;
    logic              wr_target;
    logic              wr_gain;
    logic              wr_g;
    logic              wr_acc;
    logic              wr_left;
    logic              wr_out;
    jmp_t              jmp;
    logic [STEP_W-1:0] nxt;
  } ucode_t;

  typedef struct packed {
    logic   load;
    ucode_t uc;
  } dp_ctrl_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    w.jmp = J_ALWAYS;
    w.nxt = step + 1'b1;
    case (step)
      4'd0: begin
        w.jmp = J_WAIT_IN;
      end
      4'd1: begin
        w.mul_en = 1'b1; w.a_sel = A_PEAK; w.b_sel = B_PRE;
      end
      4'd2: begin
        w.wr_level = 1'b1;
      end
      4'd3: begin
        w.mul_en = 1'b1; w.a_sel = A_DIFF; w.b_sel = B_INV;
      end
      4'd4: begin
        w.wr_target = 1'b1;
      end
      4'd5: begin
        w.mul_en = 1'b1; w.a_sel = A_GAIN; w.b_sel = B_FACTOR;
      end
      4'd6: begin
        w.wr_gain = 1'b1;
      end
      4'd7: begin
        w.mul_en = 1'b1; w.a_sel = A_GAIN; w.b_sel = B_POST;
      end
      4'd8: begin
        w.wr_g = 1'b1;
      end
      4'd9: begin
        w.mul_en = 1'b1; w.a_sel = A_MAGL; w.b_sel = B_GHI;
      end
      4'd10: begin
        w.mul_en = 1'b1; w.a_sel = A_MAGL; w.b_sel = B_GLO; w.wr_acc = 1'b1;
      end
      4'd11: begin
        w.mul_en = 1'b1; w.a_sel = A_MAGR; w.b_sel = B_GHI; w.wr_left = 1'b1;
      end
      4'd12: begin
        w.mul_en = 1'b1; w.a_sel = A_MAGR; w.b_sel = B_GLO; w.wr_acc = 1'b1;
      end
      4'd13: begin
        w.wr_out = 1'b1; w.jmp = J_WAIT_OUT; w.nxt = STEP_IDLE;
      end
      default: begin
        w.nxt = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### sv/sdc_datapath.sv
// Datapath of the stereo dynamics compressor around one shared multiplier.
`timescale 1ns / 1ps

module sdc_datapath #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sdc_pkg::dp_ctrl_t             ctrl,
  input  sdc_pkg::cfg_t                 cfg,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out
);

  localparam int AW = (SAMPLE_BITS > sdc_pkg::LEVEL_W) ? SAMPLE_BITS : sdc_pkg::LEVEL_W;
  localparam int PW = AW + sdc_pkg::B_W;
  localparam int SW = SAMPLE_BITS + 9;
  localparam int TW = sdc_pkg::TARGET_W;

  logic [SAMPLE_BITS-1:0]     samp_l_r;
  logic [SAMPLE_BITS-1:0]     samp_r_r;
  logic [SAMPLE_BITS-1:0]     mag_l;
  logic [SAMPLE_BITS-1:0]     mag_r;
  logic [SAMPLE_BITS-1:0]     peak;
  logic [AW-1:0]              a_op;
  logic [sdc_pkg::B_W-1:0]    b_op;
  logic [PW-1:0]              prod_r;
  logic [PW:0]                lev_wide;
  logic [sdc_pkg::LEVEL_W-1:0] level;
  logic [sdc_pkg::LEVEL_W-1:0] thr;
  logic [sdc_pkg::LEVEL_W-1:0] diff_r;
  logic                       above_r;
  logic [TW-1:0]              tgt;
  logic                       attack_r;
  logic [PW-1:0]              gain_wide;
  logic [sdc_pkg::GAIN_W-1:0] gain_r;
  logic [sdc_pkg::GAIN_W-1:0] gain_nxt;
  logic [sdc_pkg::G_W-1:0]    g_r;
  logic [SW-1:0]              acc_r;
  logic [PW-1:0]              psh;
  logic [SW-1:0]              sum;
  logic [SW-1:0]              lim;
  logic [SW-1:0]              clip_mag;
  logic                       clip_neg;
  logic [SAMPLE_BITS-1:0]     clip_res;
  logic [SAMPLE_BITS-1:0]     left_stage_r;
  logic [SAMPLE_BITS-1:0]     out_l_r;
  logic [SAMPLE_BITS-1:0]     out_r_r;

  assign mag_l = samp_l_r[SAMPLE_BITS-1] ? (~samp_l_r + 1'b1) : samp_l_r;
  assign mag_r = samp_r_r[SAMPLE_BITS-1] ? (~samp_r_r + 1'b1) : samp_r_r;
  assign peak  = (mag_l > mag_r) ? mag_l : mag_r;

  always_comb begin
    case (ctrl.uc.a_sel)
      sdc_pkg::A_PEAK: a_op = AW'(peak);
      sdc_pkg::A_DIFF: a_op = AW'(diff_r);
      sdc_pkg::A_GAIN: a_op = AW'(gain_r);
      sdc_pkg::A_MAGL: a_op = AW'(mag_l);
      sdc_pkg::A_MAGR: a_op = AW'(mag_r);
      default:         a_op = '0;
    endcase
  end

  always_comb begin
    case (ctrl.uc.b_sel)
      sdc_pkg::B_PRE:    b_op = sdc_pkg::B_W'(cfg.pre_gain);
      sdc_pkg::B_INV:    b_op = sdc_pkg::B_W'(cfg.inverse_ratio);
      sdc_pkg::B_FACTOR: b_op = attack_r ? cfg.attack_factor : cfg.release_factor;
      sdc_pkg::B_POST:   b_op = sdc_pkg::B_W'(cfg.post_gain);
      sdc_pkg::B_GHI:    b_op = sdc_pkg::B_W'(g_r[sdc_pkg::G_W-1:28]);
      sdc_pkg::B_GLO:    b_op = sdc_pkg::B_W'(g_r[27:0]);
      default:           b_op = '0;
    endcase
  end

  assign lev_wide = {prod_r, 1'b0} >> (SAMPLE_BITS - 8);
  assign level    = lev_wide[sdc_pkg::LEVEL_W-1:0];
  assign thr      = sdc_pkg::LEVEL_W'({cfg.threshold_level, 8'd0});

  assign tgt = above_r ? (TW'(thr) + TW'(prod_r >> 20)) : TW'(sdc_pkg::UNITY_Q28);

  assign gain_wide = prod_r >> 30;
  assign gain_nxt  = (|gain_wide[PW-1:sdc_pkg::GAIN_W]) ? '1 : gain_wide[sdc_pkg::GAIN_W-1:0];

  assign psh      = prod_r >> 28;
  assign sum      = acc_r + psh[SW-1:0];
  assign lim      = SW'(1) << (SAMPLE_BITS - 1);
  assign clip_neg = ctrl.uc.wr_left ? samp_l_r[SAMPLE_BITS-1] : samp_r_r[SAMPLE_BITS-1];

  always_comb begin
    if (clip_neg) begin
      clip_mag = (sum > lim) ? lim : sum;
      clip_res = '0 - clip_mag[SAMPLE_BITS-1:0];
    end else begin
      clip_mag = (sum > lim - 1'b1) ? (lim - 1'b1) : sum;
      clip_res = clip_mag[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= sdc_pkg::UNITY_Q28;
    end else if (ctrl.uc.wr_gain) begin
      gain_r <= gain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      samp_l_r <= left_in;
      samp_r_r <= right_in;
    end
    if (ctrl.uc.mul_en) begin
      prod_r <= PW'(a_op) * PW'(b_op);
    end
    if (ctrl.uc.wr_level) begin
      diff_r  <= level - thr;
      above_r <= level > thr;
    end
    if (ctrl.uc.wr_target) begin
      attack_r <= TW'(gain_r) > tgt;
    end
    if (ctrl.uc.wr_g) begin
      g_r <= prod_r[sdc_pkg::G_W+19:20];
    end
    if (ctrl.uc.wr_acc) begin
      acc_r <= prod_r[SW-1:0];
    end
    if (ctrl.uc.wr_left) begin
      left_stage_r <= clip_res;
    end
    if (ctrl.uc.wr_out) begin
      out_l_r <= left_stage_r;
      out_r_r <= clip_res;
    end
  end

  assign left_out  = out_l_r;
  assign right_out = out_r_r;

endmodule

### sv/stereo_dynamics_compressor.sv
// Top level of the stereo dynamics compressor: stream ports, APB registers and sequencer.
// An input transfer starts the control program, and out_tvalid rises after its final step.
// Each stereo pair takes one pass of the 14-step control program, which runs the single
// shared multiplier through eight products and their writebacks. Pairs enter only at
// the idle step. The next pair is taken while a finished result still waits on the output.
// Reset (synchronous, rst_n low) restores register defaults and unity gain, clears out_tvalid.
`timescale 1ns / 1ps

module stereo_dynamics_compressor #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // Fields from bit 0: left_sample, right_sample, zero fill.
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // Fields from bit 0: left_out, right_out, zero fill.
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [sdc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [sdc_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [sdc_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  localparam int DW = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  sdc_pkg::cfg_t                cfg_r;
  logic [sdc_pkg::REG_IW-1:0]   reg_idx;
  logic                         cfg_wr;
  logic [sdc_pkg::STEP_W-1:0]   step_r;
  logic [sdc_pkg::STEP_W-1:0]   step_nxt;
  sdc_pkg::ucode_t              uc;
  sdc_pkg::dp_ctrl_t            ctrl;
  logic                         in_xfer;
  logic                         out_free;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] left_res;
  logic signed [SAMPLE_BITS-1:0] right_res;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[sdc_pkg::CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pre_gain        <= sdc_pkg::PRE_RESET;
      cfg_r.post_gain       <= sdc_pkg::POST_RESET;
      cfg_r.threshold_level <= sdc_pkg::THR_RESET;
      cfg_r.inverse_ratio   <= sdc_pkg::INV_RESET;
      cfg_r.attack_factor   <= sdc_pkg::ATTACK_RESET;
      cfg_r.release_factor  <= sdc_pkg::RELEASE_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        sdc_pkg::REG_PRE_GAIN:  cfg_r.pre_gain        <= cfg_pwdata[sdc_pkg::PRE_W-1:0];
        sdc_pkg::REG_POST_GAIN: cfg_r.post_gain       <= cfg_pwdata[sdc_pkg::POST_W-1:0];
        sdc_pkg::REG_THRESHOLD: cfg_r.threshold_level <= cfg_pwdata[sdc_pkg::THR_W-1:0];
        sdc_pkg::REG_INV_RATIO: cfg_r.inverse_ratio   <= cfg_pwdata[sdc_pkg::INV_W-1:0];
        sdc_pkg::REG_ATTACK:    cfg_r.attack_factor   <= cfg_pwdata[sdc_pkg::FACTOR_W-1:0];
        sdc_pkg::REG_RELEASE:   cfg_r.release_factor  <= cfg_pwdata[sdc_pkg::FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sdc_pkg::REG_PRE_GAIN:  cfg_prdata = sdc_pkg::CFG_DW'(cfg_r.pre_gain);
      sdc_pkg::REG_POST_GAIN: cfg_prdata = sdc_pkg::CFG_DW'(cfg_r.post_gain);
      sdc_pkg::REG_THRESHOLD: cfg_prdata = sdc_pkg::CFG_DW'(cfg_r.threshold_level);
      sdc_pkg::REG_INV_RATIO: cfg_prdata = sdc_pkg::CFG_DW'(cfg_r.inverse_ratio);
      sdc_pkg::REG_ATTACK:    cfg_prdata = sdc_pkg::CFG_DW'(cfg_r.attack_factor);
      sdc_pkg::REG_RELEASE:   cfg_prdata = sdc_pkg::CFG_DW'(cfg_r.release_factor);
      default:                cfg_prdata = '0;
    endcase
  end

  assign uc        = sdc_pkg::ucode_rom(step_r);
  assign in_tready = (uc.jmp == sdc_pkg::J_WAIT_IN);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    case (uc.jmp)
      sdc_pkg::J_WAIT_IN:  step_nxt = in_xfer ? uc.nxt : step_r;
      sdc_pkg::J_WAIT_OUT: step_nxt = out_free ? uc.nxt : step_r;
      default:             step_nxt = uc.nxt;
    endcase
  end

  always_comb begin
    ctrl.load      = in_xfer;
    ctrl.uc        = uc;
    ctrl.uc.wr_out = uc.wr_out && out_free;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.uc.wr_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= sdc_pkg::STEP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  sdc_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .cfg      (cfg_r),
    .left_in  (in_tdata[SAMPLE_BITS-1:0]),
    .right_in (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .left_out (left_res),
    .right_out(right_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DW'({right_res, left_res});

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= sdc_pkg::STEP_LAST)
    else $error("Step counter left the control program.");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> step_r == sdc_pkg::STEP_FIRST)
    else $error("Input transfer did not start the control program.");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(step_r) == sdc_pkg::STEP_LAST)
    else $error("Result appeared outside the final step.");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == sdc_pkg::STEP_LAST && out_tvalid && !out_tready)
      |=> step_r == sdc_pkg::STEP_LAST)
    else $error("Final step left while the output was still occupied.");

endmodule

### tb/sdc_checker.sv
// Checker for the stereo dynamics compressor: register shadow, gain predictor and result compare.
`timescale 1ns / 1ps

module sdc_checker #(
  parameter int SAMPLE_BITS = 24,
  parameter int DATA_W      = 48
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [DATA_W-1:0]          in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [DATA_W-1:0]          out_tdata,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [sdc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [sdc_pkg::CFG_DW-1:0] cfg_pwdata,
  input  logic [sdc_pkg::CFG_DW-1:0] cfg_prdata,
  input  logic                       cfg_pready,
  output int                         failures,
  output int                         pending
);

  localparam logic [63:0] GAIN_MAX = 64'hFFFF_FFFF;
  localparam logic [63:0] FRAC_MASK = 64'h0FFF_FFFF;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] left_out;
    logic [SAMPLE_BITS-1:0] right_out;
  } stereo_pair_t;

  logic [sdc_pkg::PRE_W-1:0]    pre_gain_q;
  logic [sdc_pkg::POST_W-1:0]   post_gain_q;
  logic [sdc_pkg::THR_W-1:0]    threshold_q;
  logic [sdc_pkg::INV_W-1:0]    inv_ratio_q;
  logic [sdc_pkg::FACTOR_W-1:0] attack_q;
  logic [sdc_pkg::FACTOR_W-1:0] release_q;
  logic [63:0]         gain_q28;
  stereo_pair_t        expected_pairs[$];
  int                  error_count = 0;
  int                  waiting = 0;

  assign failures = error_count;
  assign pending  = waiting;

  function automatic logic [63:0] magnitude(input logic [SAMPLE_BITS-1:0] s);
    logic [63:0] v;
    v = 64'(s);
    return s[SAMPLE_BITS-1] ? (64'd1 << SAMPLE_BITS) - v : v;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] scale_and_clip(input logic [SAMPLE_BITS-1:0] s,
                                                            input logic [63:0] net_gain);
    logic [63:0] mag;
    logic [63:0] scaled;
    logic [63:0] limit;
    logic [63:0] negated;
    mag = magnitude(s);
    limit = 64'd1 << (SAMPLE_BITS - 1);
    scaled = mag * (net_gain >> 28) + ((mag * (net_gain & FRAC_MASK)) >> 28);
    if (s[SAMPLE_BITS-1]) begin
      if (scaled > limit) scaled = limit;
      negated = 64'd0 - scaled;
      return negated[SAMPLE_BITS-1:0];
    end
    if (scaled > limit - 64'd1) scaled = limit - 64'd1;
    return scaled[SAMPLE_BITS-1:0];
  endfunction

  // Advances the kept gain by one pair and returns the scaled, clipped pair.
  function automatic stereo_pair_t compress_pair(input logic [SAMPLE_BITS-1:0] left,
                                                 input logic [SAMPLE_BITS-1:0] right);
    logic [63:0] mag_l;
    logic [63:0] mag_r;
    logic [63:0] loudest;
    logic [63:0] detected;
    logic [63:0] knee;
    logic [63:0] goal;
    logic [63:0] net_gain;
    stereo_pair_t res;
    mag_l = magnitude(left);
    mag_r = magnitude(right);
    loudest = (mag_l > mag_r) ? mag_l : mag_r;
    detected = ((loudest * 64'(pre_gain_q)) << 1) >> (SAMPLE_BITS - 8);
    knee = 64'(threshold_q) << sdc_pkg::THR_SHIFT;
    if (detected > knee) begin
      goal = knee + (((detected - knee) * 64'(inv_ratio_q)) >> 20);
    end else begin
      goal = 64'(sdc_pkg::UNITY_Q28);
    end
    if (gain_q28 > goal) begin
      gain_q28 = (gain_q28 * 64'(attack_q)) >> 30;
    end else begin
      gain_q28 = (gain_q28 * 64'(release_q)) >> 30;
    end
    if (gain_q28 > GAIN_MAX) gain_q28 = GAIN_MAX;
    net_gain = (gain_q28 * 64'(post_gain_q)) >> 20;
    res.left_out = scale_and_clip(left, net_gain);
    res.right_out = scale_and_clip(right, net_gain);
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    stereo_pair_t want;
    stereo_pair_t got;
    logic [sdc_pkg::REG_IW-1:0] reg_idx;
    logic [sdc_pkg::CFG_DW-1:0] shadow;
    logic known;
    if (!rst_n) begin
      pre_gain_q = sdc_pkg::PRE_RESET;
      post_gain_q = sdc_pkg::POST_RESET;
      threshold_q = sdc_pkg::THR_RESET;
      inv_ratio_q = sdc_pkg::INV_RESET;
      attack_q = sdc_pkg::ATTACK_RESET;
      release_q = sdc_pkg::RELEASE_RESET;
      gain_q28 = 64'(sdc_pkg::UNITY_Q28);
      expected_pairs.delete();
    end else begin
      reg_idx = cfg_paddr[sdc_pkg::CFG_AW-1:2];
      if (cfg_psel && cfg_penable && cfg_pready && cfg_pwrite) begin
        case (reg_idx)
          sdc_pkg::REG_PRE_GAIN:  pre_gain_q = cfg_pwdata[sdc_pkg::PRE_W-1:0];
          sdc_pkg::REG_POST_GAIN: post_gain_q = cfg_pwdata[sdc_pkg::POST_W-1:0];
          sdc_pkg::REG_THRESHOLD: threshold_q = cfg_pwdata[sdc_pkg::THR_W-1:0];
          sdc_pkg::REG_INV_RATIO: inv_ratio_q = cfg_pwdata[sdc_pkg::INV_W-1:0];
          sdc_pkg::REG_ATTACK:    attack_q = cfg_pwdata[sdc_pkg::FACTOR_W-1:0];
          sdc_pkg::REG_RELEASE:   release_q = cfg_pwdata[sdc_pkg::FACTOR_W-1:0];
          default: ;
        endcase
      end
      if (cfg_psel && cfg_penable && cfg_pready && !cfg_pwrite) begin
        known = 1'b1;
        shadow = '0;
        case (reg_idx)
          sdc_pkg::REG_PRE_GAIN:  shadow = 32'(pre_gain_q);
          sdc_pkg::REG_POST_GAIN: shadow = 32'(post_gain_q);
          sdc_pkg::REG_THRESHOLD: shadow = 32'(threshold_q);
          sdc_pkg::REG_INV_RATIO: shadow = 32'(inv_ratio_q);
          sdc_pkg::REG_ATTACK:    shadow = 32'(attack_q);
          sdc_pkg::REG_RELEASE:   shadow = 32'(release_q);
          default:                known = 1'b0;
        endcase
        if (known && cfg_prdata !== shadow) begin
          $error("cfg_prdata mismatch: expected %0h, actual %0h", shadow, cfg_prdata);
          error_count++;
        end
      end
      if (out_tvalid && out_tready) begin
        got.left_out = out_tdata[SAMPLE_BITS-1:0];
        got.right_out = out_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        if (expected_pairs.size() == 0) begin
          $error("Result transfer arrived with no expected pair waiting.");
          error_count++;
        end else begin
          want = expected_pairs.pop_front();
          if (got.left_out !== want.left_out) begin
            $error("left_out mismatch: expected %0d, actual %0d",
                   $signed(want.left_out), $signed(got.left_out));
            error_count++;
          end
          if (got.right_out !== want.right_out) begin
            $error("right_out mismatch: expected %0d, actual %0d",
                   $signed(want.right_out), $signed(got.right_out));
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_pairs.push_back(compress_pair(in_tdata[SAMPLE_BITS-1:0],
                                               in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
      end
    end
    waiting = expected_pairs.size();
  end

endmodule

### tb/testbench.sv
// Top of the stereo dynamics compressor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int SAMPLE_BITS  = 24;
  localparam int DATA_W       = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 30;

  localparam logic [sdc_pkg::REG_IW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [sdc_pkg::REG_IW-1:0] REG_SPARE_HI = 3'd7;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [sdc_pkg::CFG_AW-1:0] cfg_paddr;
  logic [sdc_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [sdc_pkg::CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int                failures;
  int                pending;
  int                cycle_count = 0;
  int                stall_len;
  bit                steady;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  stereo_dynamics_compressor #(.SAMPLE_BITS(SAMPLE_BITS)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  sdc_checker #(.SAMPLE_BITS(SAMPLE_BITS), .DATA_W(DATA_W)) u_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready), .failures(failures), .pending(pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int idle_len();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t random_sample();
    logic [31:0] word;
    sample_t s;
    int pick;
    pick = $urandom_range(0, 9);
    word = $urandom;
    if (pick == 0) begin
      case ($urandom_range(0, 4))
        0: s = FULL_POS;
        1: s = FULL_NEG;
        2: s = '0;
        3: s = '1;
        default: s = sample_t'(1);
      endcase
    end else if (pick < 5) begin
      s = word[SAMPLE_BITS-1:0];
    end else begin
      // Spread magnitudes over many octaves so levels land on both sides of the threshold.
      word = word >> $urandom_range(32 - SAMPLE_BITS + 1, 31);
      s = word[SAMPLE_BITS-1:0];
      if ($urandom_range(0, 1) == 1) s = -s;
    end
    return s;
  endfunction

  function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
    logic [31:0] junk;
    junk = $urandom;
    if ($urandom_range(0, 1) == 0) return value;
    return value | (junk << width);
  endfunction

  task automatic apb_access(input bit write, input logic [sdc_pkg::REG_IW-1:0] idx,
                            input logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= write;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [sdc_pkg::REG_IW-1:0] idx, input logic [31:0] value,
                           input int width);
    apb_access(1'b1, idx, with_junk(value, width));
    apb_access(1'b0, idx, 32'd0);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_regs(input logic [31:0] pre, input logic [31:0] post,
                              input logic [31:0] thr, input logic [31:0] inv,
                              input logic [31:0] att, input logic [31:0] rel);
    wait_idle();
    write_reg(sdc_pkg::REG_PRE_GAIN, pre, sdc_pkg::PRE_W);
    write_reg(sdc_pkg::REG_POST_GAIN, post, sdc_pkg::POST_W);
    write_reg(sdc_pkg::REG_THRESHOLD, thr, sdc_pkg::THR_W);
    write_reg(sdc_pkg::REG_INV_RATIO, inv, sdc_pkg::INV_W);
    write_reg(sdc_pkg::REG_ATTACK, att, sdc_pkg::FACTOR_W);
    write_reg(sdc_pkg::REG_RELEASE, rel, sdc_pkg::FACTOR_W);
  endtask

  task automatic send_pair(input sample_t left, input sample_t right);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {right, left};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      send_pair(random_sample(), random_sample());
    end
  endtask

  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall_len = idle_len();
      @(negedge clk);
      if (stall_len > 0) begin
        out_tready <= 1'b0;
        repeat (stall_len) @(negedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    steady = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Writes to unmapped indexes must leave every register at its reset value.
    apb_access(1'b1, REG_SPARE_LO, $urandom);
    apb_access(1'b1, REG_SPARE_HI, $urandom);
    for (int k = sdc_pkg::REG_PRE_GAIN; k <= sdc_pkg::REG_RELEASE; k++) begin
      apb_access(1'b0, sdc_pkg::REG_IW'(k), 32'd0);
    end

    send_pair(FULL_POS, FULL_POS);
    send_pair(FULL_NEG, FULL_NEG);
    send_pair(FULL_POS, FULL_NEG);
    send_pair(FULL_NEG, FULL_POS);
    send_pair('0, '0);
    send_pair('1, sample_t'(1));
    send_pair(sample_t'(1), '1);
    send_pair({(SAMPLE_BITS/2){2'b01}}, {(SAMPLE_BITS/2){2'b10}});
    send_pair({(SAMPLE_BITS/2){2'b10}}, {(SAMPLE_BITS/2){2'b01}});
    send_pair(FULL_POS >> 1, '0);
    repeat (6) send_pair(FULL_NEG, FULL_POS);
    repeat (4) send_pair('0, '0);

    program_regs(32'h0010_0000, 32'h0010_0000, 32'h0004_0000, 32'd349525,
                 32'd1068584000, 32'd1074000000);
    run_random(300);

    // Both factors near two drive the gain into saturation.
    program_regs(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h0010_0000, 32'h0010_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_random(150);

    program_regs(32'h0010_0000, 32'h0008_0000, 32'h0004_0000, 32'h0,
                 32'h3C00_0000, 32'h4400_0000);
    run_random(300);

    program_regs(32'h0, 32'h0, 32'h0, $urandom_range(0, 32'h001F_FFFF),
                 32'h1000_0000, 32'h7FFF_FFFF);
    run_random(100);

    // Attack stays at or above one half and release at or above one, so the gain never
    // collapses to zero before the last phase.
    repeat (5) begin
      program_regs($urandom_range(0, 32'h00FF_FFFF), $urandom_range(0, 32'h00FF_FFFF),
                   $urandom_range(1, 32'h001F_FFFF), $urandom_range(0, 32'h001F_FFFF),
                   $urandom_range(32'h2000_0000, 32'h7FFF_FFFF),
                   $urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
      run_random(120);
    end

    program_regs(32'h0010_0000, 32'h0010_0000, 32'h0008_0000, 32'h0004_0000,
                 32'h7FFF_FFFF, 32'h2000_0000);
    run_random(100);

    // Zero factors pull the gain to zero for good, so this phase comes last.
    program_regs($urandom_range(0, 32'h00FF_FFFF), $urandom_range(0, 32'h00FF_FFFF),
                 $urandom_range(0, 32'h001F_FFFF), $urandom_range(0, 32'h001F_FFFF),
                 32'h0, 32'h0);
    run_random(100);

    wait_idle();
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
